/* rtl/bbz_pkg.sv */
// ----------------------------------------------------------------------------
// bbz_pkg
// Shared widths, register codes, control structs and the per-sample
// area division used by the zero-padded box blur.
// ----------------------------------------------------------------------------
package bbz_pkg;

    localparam int EXTENT_W   = 2;
    localparam int DIM_W      = 11;
    localparam int POS_W      = 2 * DIM_W;
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 4 * CHAN_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DIM_W;

    localparam int DEF_MAX_EXTENT = 3;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam logic [EXTENT_W-1:0] RST_EXTENT = 2'd1;
    localparam logic [DIM_W-1:0]    RST_WIDTH  = 11'd640;
    localparam logic [DIM_W-1:0]    RST_HEIGHT = 11'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_EXTENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic accept;
        logic scan;
        logic drain;
    } bbz_cmd_t;

    typedef struct packed {
        logic drop;
        logic emit;
        logic scan_last;
    } bbz_stat_t;

    // floor(v / (2e+1)^2) by reciprocal multiply, exact for 8-bit samples
    function automatic logic [CHAN_W-1:0] area_div(input logic [CHAN_W-1:0] v,
                                                   input logic [EXTENT_W-1:0] e);
        logic [16:0] prod;
        logic [CHAN_W-1:0] q;
        prod = '0;
        q    = v;
        unique case (e)
            2'd0:
            begin
                q = v;
            end
            2'd1:
            begin
                prod = 17'(v) * 17'd228;
                q    = CHAN_W'(prod >> 11);
            end
            2'd2:
            begin
                prod = 17'(v) * 17'd328;
                q    = CHAN_W'(prod >> 13);
            end
            2'd3:
            begin
                prod = 17'(v) * 17'd335;
                q    = CHAN_W'(prod >> 14);
            end
        endcase
        return q;
    endfunction

endpackage

/* rtl/bbz_ram.sv */
// ----------------------------------------------------------------------------
// bbz_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module bbz_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bbz_ctrl.sv */
// ----------------------------------------------------------------------------
// bbz_ctrl
// Sequencer: takes an item and, where it gives a result, walks the window
// one neighbour per cycle, then holds the result until the downstream transfer.
// ----------------------------------------------------------------------------
module bbz_ctrl
    import bbz_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  bbz_stat_t stat,
    output bbz_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_HOLD  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_valid && !stat.drop && stat.emit)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (m_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = (state_reg == ST_HOLD);
    assign cmd.accept = (state_reg == ST_IDLE) && s_valid;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.drain  = (state_reg == ST_DRAIN);

endmodule

/* rtl/bbz_datapath.sv */
// ----------------------------------------------------------------------------
// bbz_datapath
// Configuration registers, stream position, line store and the window
// accumulator with per-sample truncation and zero padding.
// ----------------------------------------------------------------------------
module bbz_datapath
    import bbz_pkg::*;
#(
    parameter int MAX_EXTENT = DEF_MAX_EXTENT,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_opcode,
    input  logic [PIX_W-1:0]      s_pixel,
    input  bbz_cmd_t              cmd,
    output bbz_stat_t             stat,
    output logic [PIX_W-1:0]      out_pixel,
    output logic                  out_last
);

    localparam int HIST_DEPTH = 2 * MAX_EXTENT * MAX_WIDTH + 2 * MAX_EXTENT + 1;
    localparam int ADDR_W     = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(2 * MAX_EXTENT + 1);
    localparam int LAG_W      = DIM_W + EXTENT_W + 1;
    localparam int XY_W       = DIM_W + 2;

    logic [EXTENT_W-1:0] extent_reg, extent_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    height_reg, height_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [ADDR_W-1:0]   wptr_reg, wptr_next;
    logic [DIM_W-1:0]    cx_reg, cx_next;
    logic [DIM_W-1:0]    cy_reg, cy_next;
    logic [ADDR_W-1:0]   base_reg, base_next;
    logic [ADDR_W-1:0]   dist_reg, dist_next;
    logic signed [XY_W-1:0] xp_reg, xp_next;
    logic signed [XY_W-1:0] yp_reg, yp_next;
    logic [CNT_W-1:0]    dx_reg, dx_next;
    logic [CNT_W-1:0]    dy_reg, dy_next;
    logic                rd_in_reg, rd_in_next;
    logic [3:0][CHAN_W-1:0] acc_reg, acc_next;
    logic                eof_reg, eof_next;

    logic [EXTENT_W-1:0] eff_e;
    logic [DIM_W-1:0]    eff_w;
    logic [DIM_W-1:0]    eff_h;
    logic [POS_W-1:0]    total;
    logic [LAG_W-1:0]    lag;
    logic [CNT_W-1:0]    two_e;
    logic signed [XY_W-1:0] e_s;
    logic                in_frame;
    logic [ADDR_W:0]     diff;
    logic [ADDR_W-1:0]   raddr;
    logic [PIX_W-1:0]    rdata;
    logic                wr_en;

    // effective configuration with clamping
    always_comb
    begin
        eff_e = extent_reg;
        if (32'(extent_reg) > MAX_EXTENT)
        begin
            eff_e = EXTENT_W'(MAX_EXTENT);
        end
        eff_w = width_reg;
        if (width_reg == '0)
        begin
            eff_w = DIM_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = DIM_W'(MAX_WIDTH);
        end
        eff_h = height_reg;
        if (height_reg == '0)
        begin
            eff_h = DIM_W'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            eff_h = DIM_W'(MAX_HEIGHT);
        end
    end

    assign total = POS_W'(eff_w) * POS_W'(eff_h);
    assign lag   = LAG_W'(eff_e) * LAG_W'(eff_w) + LAG_W'(eff_e);
    assign two_e = CNT_W'({eff_e, 1'b0});
    assign e_s   = $signed({{(XY_W - EXTENT_W){1'b0}}, eff_e});

    assign in_frame = (xp_reg >= 0) && (xp_reg < $signed({2'b00, eff_w}))
                   && (yp_reg >= 0) && (yp_reg < $signed({2'b00, eff_h}));

    // history slot of a neighbour, behind the newest write by dist
    assign diff  = {1'b0, base_reg} - {1'b0, dist_reg};
    assign raddr = diff[ADDR_W] ? ADDR_W'(diff + (ADDR_W + 1)'(HIST_DEPTH))
                                : diff[ADDR_W-1:0];

    assign wr_en = cmd.accept && (pos_reg < total) && !s_opcode;

    assign stat.drop      = (pos_reg < total) && s_opcode;
    assign stat.emit      = (pos_reg >= POS_W'(lag));
    assign stat.scan_last = (dx_reg == two_e) && (dy_reg == two_e);

    bbz_ram #(
        .WIDTH (PIX_W),
        .DEPTH (HIST_DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wptr_reg),
        .wdata (s_pixel),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        extent_next = extent_reg;
        width_next  = width_reg;
        height_next = height_reg;
        pos_next    = pos_reg;
        wptr_next   = wptr_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        base_next   = base_reg;
        dist_next   = dist_reg;
        xp_next     = xp_reg;
        yp_next     = yp_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        rd_in_next  = 1'b0;
        acc_next    = acc_reg;
        eof_next    = eof_reg;

        if (rd_in_reg)
        begin
            for (int ch = 0; ch < 4; ch++)
            begin
                acc_next[ch] = acc_reg[ch] + area_div(rdata[ch*CHAN_W +: CHAN_W], eff_e);
            end
        end

        priority if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EXTENT: extent_next = cfg_data[EXTENT_W-1:0];
                CFG_WIDTH:  width_next  = cfg_data;
                CFG_HEIGHT: height_next = cfg_data;
                default:    ;
            endcase
            if (cfg_index == CFG_EXTENT || cfg_index == CFG_WIDTH
                || cfg_index == CFG_HEIGHT)
            begin
                pos_next  = '0;
                wptr_next = '0;
                cx_next   = '0;
                cy_next   = '0;
            end
        end
        else if (cmd.accept && !stat.drop)
        begin
            pos_next  = pos_reg + POS_W'(1);
            wptr_next = (wptr_reg == ADDR_W'(HIST_DEPTH - 1)) ? '0
                                                              : wptr_reg + ADDR_W'(1);
            base_next = wptr_reg;
            dist_next = ADDR_W'({lag, 1'b0});
            xp_next   = $signed({2'b00, cx_reg}) - e_s;
            yp_next   = $signed({2'b00, cy_reg}) - e_s;
            dx_next   = '0;
            dy_next   = '0;
            acc_next  = '0;
            eof_next  = (cx_reg == eff_w - DIM_W'(1)) && (cy_reg == eff_h - DIM_W'(1));
        end
        else if (cmd.scan)
        begin
            rd_in_next = in_frame;
            if (dx_reg == two_e)
            begin
                dx_next   = '0;
                dy_next   = dy_reg + CNT_W'(1);
                xp_next   = $signed({2'b00, cx_reg}) - e_s;
                yp_next   = yp_reg + XY_W'(1);
                dist_next = dist_reg - ADDR_W'(eff_w) + ADDR_W'({eff_e, 1'b0});
            end
            else
            begin
                dx_next   = dx_reg + CNT_W'(1);
                xp_next   = xp_reg + XY_W'(1);
                dist_next = dist_reg - ADDR_W'(1);
            end
        end
        else if (cmd.drain)
        begin
            if (eof_reg)
            begin
                pos_next  = '0;
                wptr_next = '0;
                cx_next   = '0;
                cy_next   = '0;
            end
            else if (cx_reg == eff_w - DIM_W'(1))
            begin
                cx_next = '0;
                cy_next = cy_reg + DIM_W'(1);
            end
            else
            begin
                cx_next = cx_reg + DIM_W'(1);
            end
        end
        else
        begin
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extent_reg <= RST_EXTENT;
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            pos_reg    <= '0;
            wptr_reg   <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            rd_in_reg  <= 1'b0;
            eof_reg    <= 1'b0;
        end
        else
        begin
            extent_reg <= extent_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            pos_reg    <= pos_next;
            wptr_reg   <= wptr_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            rd_in_reg  <= rd_in_next;
            eof_reg    <= eof_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        dist_reg <= dist_next;
        xp_reg   <= xp_next;
        yp_reg   <= yp_next;
        acc_reg  <= acc_next;
    end

    assign out_pixel = acc_reg;
    assign out_last  = eof_reg;

endmodule

/* rtl/box_blur_zero_padded_core.sv */
// ----------------------------------------------------------------------------
// box_blur_zero_padded_core
// Streaming RGBA box blur with zero padding and per-sample truncation.
// An item that gives no result is taken without a window walk; one that
// gives a result has its window walked, one line store read per neighbour,
// and the result is held until the output transfer; the next item is
// taken the cycle after the output transfer.
// Reset: extent 1, 640 x 480 frame, stream position zero; line store not
// cleared, only entries of the current frame are ever read.
// ----------------------------------------------------------------------------
module box_blur_zero_padded_core
    import bbz_pkg::*;
#(
    parameter int MAX_EXTENT = DEF_MAX_EXTENT,
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,  // in_red, in_green, in_blue, in_alpha
    input  logic [0:0]            s_axis_tuser,  // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    output logic                  m_axis_tlast   // end_of_frame
);

    bbz_cmd_t  cmd;
    bbz_stat_t stat;

    bbz_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    bbz_datapath #(
        .MAX_EXTENT (MAX_EXTENT),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_opcode  (s_axis_tuser[0]),
        .s_pixel   (s_axis_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_pixel (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule
